### sv/chr_pkg.sv
package chr_pkg;

  localparam int NUM_ENTRIES_DEF = 16;

  localparam logic [6:0]  HEALTH_MAX     = 7'd100;
  localparam logic [15:0] VITAL_MASK_RST = 16'd31;

  localparam logic REQ_PUBLISH = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  localparam logic REG_VITAL_MASK = 1'b0;

  typedef struct packed {
    logic       req_type;
    logic [7:0] entry_index;
    logic [7:0] health_value;
    logic [7:0] mode_value;
  } req_t;

  typedef struct packed {
    logic        error_flag;
    logic        entry_present;
    logic [6:0]  entry_health;
    logic [7:0]  entry_mode;
    logic [31:0] entry_heartbeat;
    logic [6:0]  average_health;
    logic [6:0]  worst_other_health;
    logic        vital_alive;
    logic        announce_valid;
    logic [23:0] announce_word;
  } rsp_t;

  typedef struct packed {
    logic [6:0]  health;
    logic [7:0]  mode;
    logic [31:0] heartbeat;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rd_entry;
    logic upd;
    logic scan_rd;
    logic drain;
    logic div_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_last;
  } dp_stat_t;

endpackage

### sv/component_health_registry_core.sv
// Channel   Signals                                      Handshake
// -------   ------------------------------------------   -------------------------------
// request   req (req_t)                                  start && !busy
// result    rsp (rsp_t)                                  done, one cycle, no back-pressure
// config    psel penable pwrite paddr pwdata prdata      psel && penable && pwrite, pready=1
//
// Once a word is accepted, busy stays high through the read, update, entry scan, drain,
// mean divide and output states, so the next word is accepted only after the result.
// The entry scan makes one table read per cycle; the mean divider is bit-serial.
// rst is synchronous and clears the table's present bits, so no clearing pass runs.
// The result is shown for the single cycle of done; busy drops in the following cycle.
module component_health_registry_core #(
  parameter int NUM_ENTRIES = chr_pkg::NUM_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  chr_pkg::req_t  req,
  output logic           done,
  output chr_pkg::rsp_t  rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import chr_pkg::*;

  logic [15:0] vital_mask;
  ctrl_cmd_t   cmd;
  dp_stat_t    stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vital_mask <= VITAL_MASK_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_VITAL_MASK)) begin
      vital_mask <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_VITAL_MASK) ? {16'd0, vital_mask} : 32'd0;

  chr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  chr_dp #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req        (req),
    .vital_mask (vital_mask),
    .rsp        (rsp)
  );

endmodule

### sv/chr_ctrl.sv
module chr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  chr_pkg::dp_stat_t    stat,
  output chr_pkg::ctrl_cmd_t   cmd,
  output logic                 busy,
  output logic                 done
);
  import chr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_UPD   = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_RD;
      end
      S_RD:    state_next = S_UPD;
      S_UPD:   state_next = S_SCAN;
      S_SCAN: begin
        if (stat.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_DIV;
      S_DIV: begin
        if (stat.div_last) state_next = S_OUT;
      end
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = start && (state == S_IDLE);
    cmd.rd_entry = (state == S_RD);
    cmd.upd      = (state == S_UPD);
    cmd.scan_rd  = (state == S_SCAN);
    cmd.drain    = (state == S_DRAIN);
    cmd.div_step = (state == S_DIV);
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

endmodule

### sv/chr_dp.sv
module chr_dp #(
  parameter int NUM_ENTRIES = chr_pkg::NUM_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  chr_pkg::ctrl_cmd_t   cmd,
  output chr_pkg::dp_stat_t    stat,
  input  chr_pkg::req_t        req,
  input  logic [15:0]          vital_mask,
  output chr_pkg::rsp_t        rsp
);
  import chr_pkg::*;

  localparam int AW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int SUM_W = $clog2(NUM_ENTRIES * 100 + 1);
  localparam int N_W   = $clog2(NUM_ENTRIES + 1);
  localparam int DC_W  = $clog2(SUM_W);
  localparam logic [7:0]    IDX_LIM  = 8'(NUM_ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_ENTRIES - 1);

  req_t                   req_q;
  logic [NUM_ENTRIES-1:0] present_q;
  entry_t                 mem [NUM_ENTRIES];
  entry_t                 rd_data;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          idx;
  logic                   idx_ok;
  logic                   pub_ok;
  entry_t                 old_ent;
  entry_t                 new_ent;
  logic [6:0]             clamp_h;

  logic                   err_q;
  logic                   ent_p_q;
  entry_t                 ent_q;
  logic                   ann_v_q;
  logic [23:0]            ann_w_q;

  logic [AW-1:0]          scan_cnt;
  logic                   scan_v_q;
  logic                   scan_p_q;
  logic                   scan_vit_q;
  logic [SUM_W-1:0]       sum_q;
  logic [SUM_W-1:0]       sum_next;
  logic [N_W-1:0]         n_q;
  logic [N_W-1:0]         n_next;
  logic [6:0]             worst_q;
  logic [6:0]             worst_next;
  logic                   alive_q;
  logic                   alive_next;

  logic [SUM_W-1:0]       quo_q;
  logic [N_W-1:0]         rem_q;
  logic [DC_W-1:0]        dcnt;
  logic [N_W:0]           trial;
  logic [N_W:0]           diff;
  logic                   ge;

  assign idx     = req_q.entry_index[AW-1:0];
  assign idx_ok  = req_q.entry_index < IDX_LIM;
  assign pub_ok  = idx_ok && (req_q.req_type == REQ_PUBLISH);
  assign rd_addr = cmd.scan_rd ? scan_cnt : idx;
  assign clamp_h = (req_q.health_value > {1'b0, HEALTH_MAX}) ? HEALTH_MAX
                                                             : req_q.health_value[6:0];

  always_comb begin
    old_ent           = present_q[idx] ? rd_data : '0;
    new_ent.health    = clamp_h;
    new_ent.mode      = req_q.mode_value;
    new_ent.heartbeat = old_ent.heartbeat + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (cmd.rd_entry || cmd.scan_rd) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.upd && pub_ok) begin
      mem[idx] <= new_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present_q <= '0;
    end else if (cmd.upd && pub_ok) begin
      present_q[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      err_q   <= !idx_ok;
      ent_p_q <= idx_ok && (pub_ok || present_q[idx]);
      ann_v_q <= pub_ok;
      if (!idx_ok) begin
        ent_q <= '0;
      end else if (pub_ok) begin
        ent_q <= new_ent;
      end else begin
        ent_q <= old_ent;
      end
      ann_w_q <= pub_ok ? {req_q.entry_index, req_q.mode_value, 1'b0, clamp_h} : '0;
    end
  end

  always_comb begin
    sum_next   = sum_q;
    n_next     = n_q;
    worst_next = worst_q;
    alive_next = alive_q;
    if (scan_v_q && scan_p_q) begin
      sum_next = sum_q + SUM_W'(rd_data.health);
      n_next   = n_q + N_W'(1);
      if (scan_vit_q) begin
        if (rd_data.health == 7'd0) alive_next = 1'b0;
      end else if (rd_data.health < worst_q) begin
        worst_next = rd_data.health;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_v_q <= cmd.scan_rd;
    if (cmd.scan_rd) begin
      scan_p_q   <= present_q[scan_cnt];
      scan_vit_q <= vital_mask[scan_cnt];
    end
    if (cmd.upd) begin
      scan_cnt <= '0;
      sum_q    <= '0;
      n_q      <= '0;
      worst_q  <= HEALTH_MAX;
      alive_q  <= 1'b1;
    end else begin
      if (cmd.scan_rd) scan_cnt <= scan_cnt + AW'(1);
      sum_q   <= sum_next;
      n_q     <= n_next;
      worst_q <= worst_next;
      alive_q <= alive_next;
    end
  end

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign diff  = trial - {1'b0, n_q};
  assign ge    = trial >= {1'b0, n_q};

  always_ff @(posedge clk) begin
    if (cmd.drain) begin
      quo_q <= sum_next;
      rem_q <= '0;
      dcnt  <= DC_W'(SUM_W - 1);
    end else if (cmd.div_step) begin
      rem_q <= ge ? diff[N_W-1:0] : trial[N_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], ge};
      dcnt  <= dcnt - DC_W'(1);
    end
  end

  assign stat.scan_last = (scan_cnt == LAST_IDX);
  assign stat.div_last  = (dcnt == '0);

  always_comb begin
    rsp                    = '0;
    rsp.error_flag         = err_q;
    rsp.entry_present      = ent_p_q;
    rsp.entry_health       = ent_q.health;
    rsp.entry_mode         = ent_q.mode;
    rsp.entry_heartbeat    = ent_q.heartbeat;
    rsp.average_health     = (n_q == '0) ? HEALTH_MAX : quo_q[6:0];
    rsp.worst_other_health = worst_q;
    rsp.vital_alive        = alive_q;
    rsp.announce_valid     = ann_v_q;
    rsp.announce_word      = ann_w_q;
  end

endmodule

### sv/chr_checker.sv
module chr_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input chr_pkg::rsp_t  rsp
);

  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("done not followed by idle");

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted word did not raise busy");

  a_error_empty : assert property (@(posedge clk) disable iff (rst)
    done && rsp.error_flag |-> !rsp.announce_valid && !rsp.entry_present &&
                               (rsp.entry_heartbeat == 32'd0) && (rsp.announce_word == 24'd0))
    else $error("error result carries entry data");

  a_announce_match : assert property (@(posedge clk) disable iff (rst)
    done && rsp.announce_valid |-> rsp.entry_present &&
                                   (rsp.announce_word[6:0] == rsp.entry_health) &&
                                   (rsp.announce_word[15:8] == rsp.entry_mode))
    else $error("announce word disagrees with entry");

  a_aggr_range : assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.average_health <= 7'd100) && (rsp.worst_other_health <= 7'd100))
    else $error("aggregate health out of range");

endmodule

bind component_health_registry_core chr_checker u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
